/* rtl/core/two_watched_literal_clause_tracker_core_assert.svh */
// Assertion macros for the clause tracker core.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef TWO_WATCHED_LITERAL_CLAUSE_TRACKER_CORE_ASSERT_SVH
`define TWO_WATCHED_LITERAL_CLAUSE_TRACKER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TWLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TWLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/twlc_pkg.sv */
// Shared types and constants for the clause tracker core.
// No dependencies.
`timescale 1ns / 1ps
package twlc_pkg;
  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_APPEND  = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_UPDATE  = 3'd3;
  localparam logic [2:0] OP_RESCAN  = 3'd4;

  localparam logic [1:0] VAL_UNASSIGNED = 2'd0;
  localparam logic [1:0] VAL_FALSE      = 2'd1;
  localparam logic [1:0] VAL_TRUE       = 2'd2;

  localparam logic [1:0] ST_UNDECIDED = 2'd0;
  localparam logic [1:0] ST_SATISFIED = 2'd1;
  localparam logic [1:0] ST_UNIT      = 2'd2;
  localparam logic [1:0] ST_UNSAT     = 2'd3;

  typedef enum logic [3:0] {
    S_CLEARMEM, S_IDLE, S_SCAN_ADDR, S_SCAN_LIT, S_SCAN_VAL,
    S_UPD_W1, S_UPD_W2, S_UPD_DEC, S_OUT
  } state_t;
endpackage

/* rtl/core/two_watched_literal_clause_tracker_core.sv */
// Top level of the two-watched-literal clause tracker.
// Depends on twlc_pkg, twlc_ram and the assertion macro header.
`timescale 1ns / 1ps
//
// Usage: one word enters on the in_ channel (opcode, variable, value,
// polarity, satisfies) and exactly one word leaves on the out_ channel with
// the clause status and both watch positions after that word.
// Work is one word at a time; in_ready is low from acceptance until the
// result is registered in the output stage.
// Clear, append and write go from idle straight to the output state.
// Write-and-update and rescan walk the clause over the literal memory and
// the assignment memory, each literal in turn through the ADDR, LIT and
// VAL scan states, as each memory has a single read port. Rescan walks
// it once; the update with satisfies low may walk it twice (one search
// per watch).
// Reset: the assignment memory is swept to unassigned, one entry a cycle,
// while in_ready stays low. Status resets to unsatisfied with no watches
// and an empty clause.
// Stall: the result holds in out_ registers until out_ready; a new word may
// be accepted while that result waits, but it only finishes after it leaves.
//
module two_watched_literal_clause_tracker_core #(
  parameter int MAX_LITERALS  = 16,
  parameter int NUM_VARIABLES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [9:0] in_variable,
  input  logic [1:0] in_value,
  input  logic       in_polarity,
  input  logic       in_satisfies,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_clause_state,
  output logic       out_first_valid,
  output logic [3:0] out_first_position,
  output logic       out_second_valid,
  output logic [3:0] out_second_position
);
  `include "two_watched_literal_clause_tracker_core_assert.svh"

  localparam int LW = $clog2(MAX_LITERALS);
  localparam int CW = $clog2(MAX_LITERALS + 1);
  localparam int VW = $clog2(NUM_VARIABLES);
  localparam int VDW = ($clog2(NUM_VARIABLES + 1) > 10) ? $clog2(NUM_VARIABLES + 1) : 10;

  // stored request
  logic [2:0]  op_r;
  logic [9:0]  var_r;
  logic [1:0]  val_r;
  logic        pol_r, sat_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] fw_r, fw_nxt, sw_r, sw_nxt;
  logic          fp_r, fp_nxt, sp_r, sp_nxt;
  logic [1:0]    status_r, status_nxt;
  twlc_pkg::state_t state_r, state_nxt;

  // scan state
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pass_r, pass_nxt;    // update: 0 first search, 1 second
  logic          hit_r, hit_nxt;
  logic [LW-1:0] hidx_r, hidx_nxt;
  logic [10:0]   lit_r, lit_nxt;      // literal latched for value compare
  logic [VW-1:0] clr_r;
  // watch evaluation results (captured from the watched literals)
  logic          w1sat_r, w1sat_nxt, w1uns_r, w1uns_nxt, w1var_r, w1var_nxt;
  logic          w2sat_r, w2sat_nxt, w2uns_r, w2uns_nxt, w2var_r, w2var_nxt;
  logic          on1_r, on1_nxt, on2_r, on2_nxt;

  // memories
  logic          lm_we;
  logic [LW-1:0] lm_waddr, lm_raddr;
  logic [10:0]   lm_wdata, lm_rdata;
  logic          am_we;
  logic [VW-1:0] am_waddr, am_raddr;
  logic [1:0]    am_wdata, am_rdata;

  twlc_ram #(.WIDTH(11), .DEPTH(MAX_LITERALS)) u_lit_ram (
    .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
    .raddr(lm_raddr), .rdata(lm_rdata));
  twlc_ram #(.WIDTH(2), .DEPTH(NUM_VARIABLES)) u_asg_ram (
    .clk(clk), .we(am_we), .waddr(am_waddr), .wdata(am_wdata),
    .raddr(am_raddr), .rdata(am_rdata));

  logic out_vld_r;
  logic [1:0] o_st_r;
  logic o_fv_r, o_sv_r;
  logic [3:0] o_fp_r, o_sp_r;

  // literal fields and variable range
  logic [VDW-1:0] lvar_ext, rvar_ext;
  logic           lvar_ok, rvar_ok;
  logic [1:0]     lval;           // value of latched literal's variable
  logic           ltrue;
  assign lvar_ext = VDW'(lit_r[10:1]);
  assign rvar_ext = VDW'(var_r);
  assign lvar_ok  = lvar_ext < VDW'(NUM_VARIABLES);
  assign rvar_ok  = rvar_ext < VDW'(NUM_VARIABLES);
  assign lval     = lvar_ok ? am_rdata : twlc_pkg::VAL_UNASSIGNED;
  assign ltrue    = lit_r[0] ? (lval == twlc_pkg::VAL_TRUE) : (lval == twlc_pkg::VAL_FALSE);

  logic          in_acc;
  logic [CW-1:0] idx_last;
  logic [1:0]    val_wr;
  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == twlc_pkg::S_IDLE);
  assign idx_last = count_r - CW'(1);
  assign val_wr   = (val_r == 2'd3) ? twlc_pkg::VAL_UNASSIGNED : val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= twlc_pkg::S_CLEARMEM;
      clr_r    <= '0;
      count_r  <= '0;
      fp_r     <= 1'b0;
      sp_r     <= 1'b0;
      fw_r     <= '0;
      sw_r     <= '0;
      status_r <= twlc_pkg::ST_UNSAT;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (state_r == twlc_pkg::S_CLEARMEM) clr_r <= clr_r + VW'(1);
      count_r  <= count_nxt;
      fp_r <= fp_nxt; sp_r <= sp_nxt; fw_r <= fw_nxt; sw_r <= sw_nxt;
      status_r <= status_nxt;
      if (state_r == twlc_pkg::S_OUT && (!out_vld_r || out_ready)) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_opcode; var_r <= in_variable; val_r <= in_value;
      pol_r <= in_polarity; sat_r <= in_satisfies;
    end
    idx_r <= idx_nxt; pass_r <= pass_nxt; hit_r <= hit_nxt; hidx_r <= hidx_nxt;
    lit_r <= lit_nxt;
    w1sat_r <= w1sat_nxt; w1uns_r <= w1uns_nxt; w1var_r <= w1var_nxt;
    w2sat_r <= w2sat_nxt; w2uns_r <= w2uns_nxt; w2var_r <= w2var_nxt;
    on1_r <= on1_nxt; on2_r <= on2_nxt;
    if (state_r == twlc_pkg::S_OUT && (!out_vld_r || out_ready)) begin
      o_st_r <= status_nxt;
      o_fv_r <= fp_nxt; o_sv_r <= sp_nxt;
      o_fp_r <= fp_nxt ? 4'(fw_nxt) : 4'd0;
      o_sp_r <= sp_nxt ? 4'(sw_nxt) : 4'd0;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_clause_state    = o_st_r;
  assign out_first_valid     = o_fv_r;
  assign out_first_position  = o_fp_r;
  assign out_second_valid    = o_sv_r;
  assign out_second_position = o_sp_r;

  // Sequencer. Update writes the variable, evaluates both watches (W1, W2 read
  // the two watched literals, DEC decides), then scans if needed. Each scan step:
  // ADDR reads the literal, LIT latches it and reads its variable, VAL evaluates.
  always_comb begin
    logic lmatch;
    logic fw_uns_eff;
    logic scan_restart;
    state_nxt = state_r;
    count_nxt = count_r;
    fw_nxt = fw_r; sw_nxt = sw_r; fp_nxt = fp_r; sp_nxt = sp_r;
    status_nxt = status_r;
    idx_nxt = idx_r; pass_nxt = pass_r; hit_nxt = hit_r; hidx_nxt = hidx_r;
    lit_nxt = lit_r;
    w1sat_nxt = w1sat_r; w1uns_nxt = w1uns_r; w1var_nxt = w1var_r;
    w2sat_nxt = w2sat_r; w2uns_nxt = w2uns_r; w2var_nxt = w2var_r;
    on1_nxt = on1_r; on2_nxt = on2_r;
    lm_we = 1'b0; lm_waddr = count_r[LW-1:0]; lm_wdata = {var_r, pol_r};
    lm_raddr = idx_r[LW-1:0];
    am_we = 1'b0; am_waddr = var_r[VW-1:0]; am_wdata = val_wr;
    lmatch = (lit_r[10:1] == var_r) && (lit_r[0] == (val_r == twlc_pkg::VAL_TRUE));
    fw_uns_eff = 1'b0;
    scan_restart = 1'b0;
    unique case (state_r)
      twlc_pkg::S_CLEARMEM: begin
        am_we = 1'b1; am_waddr = clr_r; am_wdata = twlc_pkg::VAL_UNASSIGNED;
        if (clr_r == VW'(NUM_VARIABLES - 1)) state_nxt = twlc_pkg::S_IDLE;
      end
      twlc_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0; pass_nxt = 1'b0; hit_nxt = 1'b0; hidx_nxt = '0;
          unique case (in_opcode)
            twlc_pkg::OP_UPDATE: state_nxt = twlc_pkg::S_UPD_W1;
            twlc_pkg::OP_RESCAN: begin
              fp_nxt = 1'b0; sp_nxt = 1'b0; fw_nxt = '0; sw_nxt = '0;
              state_nxt = (count_r == '0) ? twlc_pkg::S_UPD_DEC : twlc_pkg::S_SCAN_ADDR;
            end
            default: state_nxt = twlc_pkg::S_OUT;
          endcase
        end
      end
      twlc_pkg::S_UPD_W1: begin
        // write the variable first, then read the first watched literal
        if (rvar_ok) am_we = 1'b1;
        lm_raddr = fw_r;
        state_nxt = twlc_pkg::S_UPD_W2;
      end
      twlc_pkg::S_UPD_W2: begin
        lit_nxt = lm_rdata;
        lm_raddr = sw_r;
        state_nxt = twlc_pkg::S_UPD_DEC;
        pass_nxt = 1'b0;
      end
      twlc_pkg::S_UPD_DEC: begin
        if (op_r == twlc_pkg::OP_RESCAN) begin
          status_nxt = (fp_r && w1sat_r) ? twlc_pkg::ST_SATISFIED :
                       sp_r ? twlc_pkg::ST_UNDECIDED :
                       fp_r ? twlc_pkg::ST_UNIT : twlc_pkg::ST_UNSAT;
          state_nxt = twlc_pkg::S_OUT;
        end else if (!pass_r) begin
          // evaluate first watch from lit_r/am_rdata, fetch second
          w1sat_nxt = fp_r && ltrue;
          w1uns_nxt = !fp_r || (lval != twlc_pkg::VAL_UNASSIGNED && !ltrue);
          w1var_nxt = fp_r && (lit_r[10:1] == var_r);
          on1_nxt   = fp_r && lmatch;
          lit_nxt = lm_rdata;
          pass_nxt = 1'b1;
        end else begin
          w2sat_nxt = sp_r && ltrue;
          w2uns_nxt = !sp_r || (lval != twlc_pkg::VAL_UNASSIGNED && !ltrue);
          w2var_nxt = sp_r && (lit_r[10:1] == var_r);
          on2_nxt   = sp_r && lmatch;
          pass_nxt = 1'b0;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          if (sat_r) begin
            if (status_r != twlc_pkg::ST_SATISFIED && !on1_r && !(sp_r && lmatch)
                && count_r != '0) begin
              state_nxt = twlc_pkg::S_SCAN_ADDR;
            end else begin
              status_nxt = twlc_pkg::ST_SATISFIED;
              state_nxt = twlc_pkg::S_OUT;
            end
          end else if (fp_r && !w1var_r && sp_r && (lit_r[10:1] != var_r)) begin
            state_nxt = twlc_pkg::S_OUT;
          end else if (w1uns_r) begin
            // search a new first watch
            fp_nxt = 1'b0; fw_nxt = '0;
            w2uns_nxt = !sp_r || (lval != twlc_pkg::VAL_UNASSIGNED && !ltrue);
            state_nxt = (count_r == '0) ? twlc_pkg::S_OUT : twlc_pkg::S_SCAN_ADDR;
            pass_nxt = 1'b0;
            if (count_r == '0) begin
              sp_nxt = 1'b0; sw_nxt = '0;
              status_nxt = twlc_pkg::ST_UNSAT;
            end
          end else begin
            fw_uns_eff = (sp_r == fp_r && sw_r == fw_r) ||
                         (!sp_r || (lval != twlc_pkg::VAL_UNASSIGNED && !ltrue));
            if (fw_uns_eff) begin
              sp_nxt = 1'b0; sw_nxt = '0;
              pass_nxt = 1'b1;
              state_nxt = (count_r == '0) ? twlc_pkg::S_OUT : twlc_pkg::S_SCAN_ADDR;
            end else begin
              status_nxt = ((status_r == twlc_pkg::ST_SATISFIED) &&
                            (w1sat_r || (sp_r && ltrue))) ? twlc_pkg::ST_SATISFIED :
                           twlc_pkg::ST_UNDECIDED;
              state_nxt = twlc_pkg::S_OUT;
            end
          end
        end
      end
      twlc_pkg::S_SCAN_ADDR: begin
        lm_raddr = idx_r[LW-1:0];
        state_nxt = twlc_pkg::S_SCAN_LIT;
      end
      twlc_pkg::S_SCAN_LIT: begin
        lit_nxt = lm_rdata;
        state_nxt = twlc_pkg::S_SCAN_VAL;
      end
      twlc_pkg::S_SCAN_VAL: begin
        state_nxt = twlc_pkg::S_SCAN_ADDR;
        if (op_r == twlc_pkg::OP_RESCAN) begin
          if (ltrue) begin
            sw_nxt = fw_r; sp_nxt = fp_r; fw_nxt = idx_r[LW-1:0]; fp_nxt = 1'b1;
            w1sat_nxt = 1'b1;
          end else if (lval == twlc_pkg::VAL_UNASSIGNED) begin
            if (!fp_r) begin
              fw_nxt = idx_r[LW-1:0]; fp_nxt = 1'b1; w1sat_nxt = 1'b0;
            end else if (!sp_r) begin
              sw_nxt = idx_r[LW-1:0]; sp_nxt = 1'b1;
            end
          end
          if (idx_r == idx_last) state_nxt = twlc_pkg::S_UPD_DEC;
          if (idx_r == '0 && !ltrue && !(lval == twlc_pkg::VAL_UNASSIGNED))
            w1sat_nxt = 1'b0;
          if (idx_r == '0 && lval == twlc_pkg::VAL_UNASSIGNED) w1sat_nxt = 1'b0;
          if (idx_r == idx_last) pass_nxt = 1'b0;
        end else if (sat_r) begin
          if (lmatch) begin
            if (!w1sat_r) begin
              sw_nxt = fw_r; sp_nxt = fp_r; fw_nxt = idx_r[LW-1:0]; fp_nxt = 1'b1;
            end else if (!w2sat_r) begin
              sw_nxt = idx_r[LW-1:0]; sp_nxt = 1'b1;
            end
            status_nxt = twlc_pkg::ST_SATISFIED;
            state_nxt = twlc_pkg::S_OUT;
          end else if (idx_r == idx_last) begin
            status_nxt = twlc_pkg::ST_SATISFIED;
            state_nxt = twlc_pkg::S_OUT;
          end
        end else begin
          // pass 0: new first watch; pass 1: new second watch
          if (lval == twlc_pkg::VAL_UNASSIGNED &&
              !(pass_r && fp_r && idx_r[LW-1:0] == fw_r) && !hit_r) begin
            hit_nxt = 1'b1;
            if (!pass_r) begin
              fw_nxt = idx_r[LW-1:0]; fp_nxt = 1'b1;
            end else begin
              sw_nxt = idx_r[LW-1:0]; sp_nxt = 1'b1;
            end
          end
          if (idx_r == idx_last || (lval == twlc_pkg::VAL_UNASSIGNED &&
              !(pass_r && fp_r && idx_r[LW-1:0] == fw_r))) begin
            idx_nxt = '0;
            hit_nxt = 1'b0;
            if (!pass_r) begin
              // first watch done; decide whether the second needs a search
              pass_nxt = 1'b1;
              if ((sp_r == fp_nxt && (!sp_r || sw_r == fw_nxt)) || w2uns_r) begin
                sp_nxt = 1'b0; sw_nxt = '0;
                scan_restart = 1'b1;
              end else begin
                state_nxt = twlc_pkg::S_OUT;
                status_nxt = ((status_r == twlc_pkg::ST_SATISFIED) && w2sat_r) ?
                             twlc_pkg::ST_SATISFIED : twlc_pkg::ST_UNDECIDED;
              end
            end else begin
              state_nxt = twlc_pkg::S_OUT;
              status_nxt = ((status_r == twlc_pkg::ST_SATISFIED) &&
                            ((fp_nxt && !w1uns_r && w1sat_r))) ? twlc_pkg::ST_SATISFIED :
                           sp_nxt ? twlc_pkg::ST_UNDECIDED :
                           fp_nxt ? twlc_pkg::ST_UNIT : twlc_pkg::ST_UNSAT;
            end
          end
        end
        // advance to the next literal unless the second search starts over
        if (state_nxt == twlc_pkg::S_SCAN_ADDR && !scan_restart)
          idx_nxt = idx_r + CW'(1);
      end
      twlc_pkg::S_OUT: begin
        if (!out_vld_r || out_ready) begin
          state_nxt = twlc_pkg::S_IDLE;
          unique case (op_r)
            twlc_pkg::OP_CLEAR: begin
              count_nxt = '0; fp_nxt = 1'b0; sp_nxt = 1'b0; fw_nxt = '0; sw_nxt = '0;
              status_nxt = twlc_pkg::ST_UNSAT;
            end
            twlc_pkg::OP_APPEND: begin
              if (count_r < CW'(MAX_LITERALS)) begin
                lm_we = 1'b1;
                count_nxt = count_r + CW'(1);
                fw_nxt = '0; fp_nxt = 1'b1;
                sp_nxt = (count_r != '0);
                sw_nxt = (count_r != '0) ? LW'(1) : '0;
                status_nxt = (count_r != '0) ? twlc_pkg::ST_UNDECIDED : twlc_pkg::ST_UNIT;
              end
            end
            twlc_pkg::OP_WRITE: am_we = rvar_ok;
            default: ;
          endcase
        end
      end
      default: state_nxt = twlc_pkg::S_IDLE;
    endcase
    // read the variable of the literal latched at this edge
    am_raddr = lit_nxt[VW:1];
  end

  // Results for clear/append are committed in S_OUT; present them directly.
  `TWLC_ASSERT_IMPL(a_ready_idle, in_ready, state_r == twlc_pkg::S_IDLE)
  `TWLC_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid)
  `TWLC_ASSERT_IMPL(a_count_cap, 1'b1, count_r <= CW'(MAX_LITERALS))
endmodule

/* rtl/core/twlc_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module twlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* tb/two_watched_literal_clause_tracker_checker.sv */
// Checker for the clause tracker: watches both channels, predicts each result word
// and compares it field by field. Depends on twlc_pkg.
`timescale 1ns / 1ps
module two_watched_literal_clause_tracker_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [9:0] in_variable,
  input  logic [1:0] in_value,
  input  logic       in_polarity,
  input  logic       in_satisfies,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_clause_state,
  input  logic       out_first_valid,
  input  logic [3:0] out_first_position,
  input  logic       out_second_valid,
  input  logic [3:0] out_second_position,
  output int         fail_count,
  output int         pending_count,
  output int         result_count
);
  localparam int LITS = 16;
  localparam int VARS = 1024;

  typedef struct packed {
    logic [1:0] clause_state;
    logic       first_valid;
    logic [3:0] first_position;
    logic       second_valid;
    logic [3:0] second_position;
  } status_word_t;

  logic [9:0] lit_var_q [LITS];
  logic       lit_pos_q [LITS];
  int         lit_count;
  logic [1:0] assign_q [VARS];
  int         w1, w2;
  logic       w1_on, w2_on;
  logic [1:0] status;
  status_word_t status_queue[$];

  function automatic logic lit_true(int p);
    logic [1:0] a;
    a = assign_q[lit_var_q[p]];
    return lit_pos_q[p] ? (a == twlc_pkg::VAL_TRUE) : (a == twlc_pkg::VAL_FALSE);
  endfunction

  function automatic logic watch_false(logic on, int p);
    if (!on) return 1'b1;
    return assign_q[lit_var_q[p]] != twlc_pkg::VAL_UNASSIGNED && !lit_true(p);
  endfunction

  function automatic logic first_free(logic skip_on, int skip, output int found);
    found = 0;
    for (int i = 0; i < lit_count; i++)
      if (assign_q[lit_var_q[i]] == twlc_pkg::VAL_UNASSIGNED && !(skip_on && i == skip)) begin
        found = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  task automatic settle(logic keep_sat);
    logic sat;
    sat = (w1_on && lit_true(w1)) || (w2_on && lit_true(w2));
    if (keep_sat && sat) status = twlc_pkg::ST_SATISFIED;
    else if (w2_on) status = twlc_pkg::ST_UNDECIDED;
    else if (w1_on) status = twlc_pkg::ST_UNIT;
    else status = twlc_pkg::ST_UNSAT;
  endtask

  task automatic watch_update(logic [9:0] v, logic [1:0] val, logic sat_flag);
    logic pos, on1, on2, hit;
    int idx;
    if (sat_flag) begin
      pos = (val == twlc_pkg::VAL_TRUE);
      on1 = w1_on && lit_var_q[w1] == v && lit_pos_q[w1] == pos;
      on2 = w2_on && lit_var_q[w2] == v && lit_pos_q[w2] == pos;
      if (status != twlc_pkg::ST_SATISFIED && !on1 && !on2) begin
        hit = 1'b0;
        idx = 0;
        for (int i = 0; i < lit_count; i++)
          if (!hit && lit_var_q[i] == v && lit_pos_q[i] == pos) begin
            idx = i;
            hit = 1'b1;
          end
        if (hit) begin
          if (!(w1_on && lit_true(w1))) begin
            w2 = w1; w2_on = w1_on; w1 = idx; w1_on = 1'b1;
          end else if (!(w2_on && lit_true(w2))) begin
            w2 = idx; w2_on = 1'b1;
          end
        end
      end
      status = twlc_pkg::ST_SATISFIED;
      return;
    end
    if (w1_on && lit_var_q[w1] != v && w2_on && lit_var_q[w2] != v) return;
    if (watch_false(w1_on, w1)) w1_on = first_free(1'b0, 0, w1);
    if ((w2_on == w1_on && (!w2_on || w2 == w1)) || watch_false(w2_on, w2))
      w2_on = first_free(w1_on, w1, w2);
    settle(status == twlc_pkg::ST_SATISFIED);
  endtask

  // Apply one accepted word to the shadow state and queue its status word.
  task automatic apply_word(logic [2:0] op, logic [9:0] v, logic [1:0] val,
                            logic pol, logic sat_flag);
    status_word_t r;
    case (op)
      twlc_pkg::OP_CLEAR: begin
        lit_count = 0; w1 = 0; w2 = 0; w1_on = 0; w2_on = 0;
        status = twlc_pkg::ST_UNSAT;
      end
      twlc_pkg::OP_APPEND: begin
        if (lit_count < LITS) begin
          lit_var_q[lit_count] = v;
          lit_pos_q[lit_count] = pol;
          lit_count++;
          w1 = 0; w1_on = 1'b1;
          if (lit_count > 1) begin
            w2 = 1; w2_on = 1'b1; status = twlc_pkg::ST_UNDECIDED;
          end else begin
            w2 = 0; w2_on = 1'b0; status = twlc_pkg::ST_UNIT;
          end
        end
      end
      twlc_pkg::OP_WRITE: assign_q[v] = (val == 2'd3) ? twlc_pkg::VAL_UNASSIGNED : val;
      twlc_pkg::OP_UPDATE: begin
        assign_q[v] = (val == 2'd3) ? twlc_pkg::VAL_UNASSIGNED : val;
        watch_update(v, val, sat_flag);
      end
      twlc_pkg::OP_RESCAN: begin
        w1_on = 0; w2_on = 0; w1 = 0; w2 = 0;
        for (int i = 0; i < lit_count; i++) begin
          if (lit_true(i)) begin
            w2 = w1; w2_on = w1_on; w1 = i; w1_on = 1'b1;
          end else if (assign_q[lit_var_q[i]] == twlc_pkg::VAL_UNASSIGNED) begin
            if (!w1_on) begin
              w1 = i; w1_on = 1'b1;
            end else if (!w2_on) begin
              w2 = i; w2_on = 1'b1;
            end
          end
        end
        settle(1'b1);
      end
      default: ;
    endcase
    r.clause_state = status;
    r.first_valid = w1_on;
    r.first_position = w1_on ? w1[3:0] : 4'd0;
    r.second_valid = w2_on;
    r.second_position = w2_on ? w2[3:0] : 4'd0;
    status_queue.push_back(r);
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
    lit_count = 0;
    w1 = 0; w2 = 0; w1_on = 0; w2_on = 0;
    status = twlc_pkg::ST_UNSAT;
    for (int i = 0; i < VARS; i++) assign_q[i] = twlc_pkg::VAL_UNASSIGNED;
    for (int i = 0; i < LITS; i++) begin
      lit_var_q[i] = '0;
      lit_pos_q[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    status_word_t e;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (status_queue.size() == 0) begin
        $error("result word with no expectation waiting");
        fail_count++;
      end else begin
        e = status_queue.pop_front();
        if (out_clause_state !== e.clause_state) begin
          $error("clause_state: expected %0d got %0d", e.clause_state, out_clause_state);
          fail_count++;
        end
        if (out_first_valid !== e.first_valid) begin
          $error("first_valid: expected %0d got %0d", e.first_valid, out_first_valid);
          fail_count++;
        end
        if (out_first_position !== e.first_position) begin
          $error("first_position: expected %0d got %0d", e.first_position,
                 out_first_position);
          fail_count++;
        end
        if (out_second_valid !== e.second_valid) begin
          $error("second_valid: expected %0d got %0d", e.second_valid, out_second_valid);
          fail_count++;
        end
        if (out_second_position !== e.second_position) begin
          $error("second_position: expected %0d got %0d", e.second_position,
                 out_second_position);
          fail_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready)
      apply_word(in_opcode, in_variable, in_value, in_polarity, in_satisfies);
    pending_count = status_queue.size();
  end
endmodule

/* tb/two_watched_literal_clause_tracker_core_tb.sv */
// Testbench top for the clause tracker core: clock, reset, stimulus and verdict.
// Depends on twlc_pkg, the core and two_watched_literal_clause_tracker_checker.
`timescale 1ns / 1ps
module two_watched_literal_clause_tracker_core_tb;

  // Stall-free cycles after the last result before the verdict.
  localparam int DRAIN_CYCLES = 200;
  // Idle cycles tolerated with no word moving; covers the reset memory sweep
  // and the slowest update while the result side stalls.
  localparam int WATCHDOG_LIMIT = 5000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_opcode = '0;
  logic [9:0] in_variable = '0;
  logic [1:0] in_value = '0;
  logic       in_polarity = 1'b0;
  logic       in_satisfies = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_clause_state;
  logic       out_first_valid;
  logic [3:0] out_first_position;
  logic       out_second_valid;
  logic [3:0] out_second_position;
  int         fail_count, pending_count, result_count;
  int         idle_cycles;
  int         words_sent;
  bit         busy_phase;  // when set, both sides idle at random
  int         clause_len;

  always #5 clk = ~clk;

  two_watched_literal_clause_tracker_core dut (.*);
  two_watched_literal_clause_tracker_checker checker_i (.*);

  // Drive ready at the falling edge; idle about a third of the time in the busy phase.
  always @(negedge clk)
    out_ready <= busy_phase ? ($urandom_range(99) >= 34) : 1'b1;

  // Watchdog: count cycles where no word crosses either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("FAIL two_watched_literal_clause_tracker_core");
      $finish;
    end
  end

  // Send one word: optional random gap with valid low, then hold valid until
  // accepted. Valid stays up after acceptance until the next call decides.
  task automatic send_word(logic [2:0] op, logic [9:0] v, logic [1:0] val,
                           logic pol, logic sat_flag);
    while (busy_phase && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_variable  <= v;
    in_value     <= val;
    in_polarity  <= pol;
    in_satisfies <= sat_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Pick a variable from a small pool so literals and writes collide often.
  function automatic logic [9:0] pick_var();
    return ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(7));
  endfunction

  initial begin
    idle_cycles = 0;
    words_sent = 0;
    busy_phase = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty clause, unit clause, full clause and overflow, extremes.
    send_word(twlc_pkg::OP_RESCAN, 10'd0, twlc_pkg::VAL_UNASSIGNED, 1'b0, 1'b0);
    send_word(twlc_pkg::OP_UPDATE, 10'd1023, twlc_pkg::VAL_TRUE, 1'b1, 1'b0);
    send_word(twlc_pkg::OP_APPEND, 10'd1023, twlc_pkg::VAL_UNASSIGNED, 1'b1, 1'b0);
    send_word(twlc_pkg::OP_UPDATE, 10'd1023, twlc_pkg::VAL_FALSE, 1'b0, 1'b0);
    send_word(twlc_pkg::OP_RESCAN, 10'd0, twlc_pkg::VAL_UNASSIGNED, 1'b0, 1'b0);
    send_word(twlc_pkg::OP_CLEAR, 10'd0, twlc_pkg::VAL_UNASSIGNED, 1'b0, 1'b0);
    for (int i = 0; i < 17; i++)
      send_word(twlc_pkg::OP_APPEND, 10'(i), twlc_pkg::VAL_UNASSIGNED, i[0], 1'b0);
    send_word(twlc_pkg::OP_WRITE, 10'd5, 2'd3, 1'b0, 1'b0);
    send_word(twlc_pkg::OP_UPDATE, 10'd3, twlc_pkg::VAL_TRUE, 1'b0, 1'b1);
    send_word(3'd5, 10'd0, twlc_pkg::VAL_UNASSIGNED, 1'b0, 1'b0);
    send_word(3'd7, 10'h3ff, 2'd3, 1'b1, 1'b1);

    // Random: mostly build a short clause, then run assignments against it.
    while (words_sent < 520) begin
      busy_phase = (words_sent < 400);
      send_word(twlc_pkg::OP_CLEAR, 10'd0, twlc_pkg::VAL_UNASSIGNED, 1'b0, 1'b0);
      clause_len = ($urandom_range(9) == 0) ? 17 : $urandom_range(1, 6);
      for (int i = 0; i < clause_len; i++)
        send_word(twlc_pkg::OP_APPEND, pick_var(), 2'($urandom_range(3)), 1'($urandom),
                  1'($urandom));
      repeat ($urandom_range(4, 14)) begin
        case ($urandom_range(9))
          0, 1:    send_word(twlc_pkg::OP_WRITE, pick_var(), 2'($urandom_range(3)),
                             1'($urandom), 1'($urandom));
          2:       send_word(twlc_pkg::OP_RESCAN, 10'($urandom), 2'($urandom),
                             1'($urandom), 1'($urandom));
          3:       send_word(3'($urandom_range(5, 7)), 10'($urandom), 2'($urandom),
                             1'($urandom), 1'($urandom));
          4:       send_word(twlc_pkg::OP_APPEND, pick_var(), 2'($urandom), 1'($urandom),
                             1'($urandom));
          default: send_word(twlc_pkg::OP_UPDATE, pick_var(), 2'($urandom_range(3)),
                             1'($urandom), 1'($urandom));
        endcase
      end
    end

    busy_phase = 1'b0;
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words, checked %0d results across clauses up to overflow size",
             words_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS two_watched_literal_clause_tracker_core");
    end else begin
      $display("FAIL two_watched_literal_clause_tracker_core");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/twlc_pkg.sv
rtl/core/twlc_ram.sv
rtl/core/two_watched_literal_clause_tracker_core.sv
tb/two_watched_literal_clause_tracker_checker.sv
tb/two_watched_literal_clause_tracker_core_tb.sv
